FILE: rtl/sv39ptw_pkg.sv
// shared types and constants for the sv39 page table walker
`timescale 1ns / 1ps

package sv39ptw_pkg;

	localparam int unsigned STORE_ENTRIES_DEF = 4096;

	localparam int ADDR_W     = 56;
	localparam int DATA_W     = 64;
	localparam int VA_W       = 39;
	localparam int WORD_W     = ADDR_W - 3;
	localparam int VPN_W      = 9;
	localparam int PPN_LSB    = 10;
	localparam int PPN_W      = 44;
	localparam int PAGE_SHIFT = 12;

	// pte flag positions
	localparam int BIT_V = 0;
	localparam int BIT_R = 1;
	localparam int BIT_X = 3;
	localparam int BIT_A = 6;
	localparam int BIT_D = 7;

	// stream packing
	localparam int IN_TDATA_W  = 216;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 120;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_XLATE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SLOT,
		ST_READ,
		ST_HOLD
	} walk_state_t;

	typedef struct packed {
		logic re;
		logic we;
	} mem_cmd_t;

endpackage

FILE: rtl/sv39ptw_slot.sv
// word address to store slot reduction (modulo store depth)
`timescale 1ns / 1ps

module sv39ptw_slot #(
	parameter int unsigned STORE_ENTRIES = sv39ptw_pkg::STORE_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [sv39ptw_pkg::WORD_W-1:0]        word,
	output logic                                  done,
	output logic [$clog2(STORE_ENTRIES)-1:0]      slot
);
	import sv39ptw_pkg::*;

	localparam int IDX_W = $clog2(STORE_ENTRIES);

	// 2^bits mod depth, evaluated at elaboration
	function automatic int unsigned pow2_mod(input int bits);
		longint unsigned w;
		w = 1;
		for (int b = 0; b < bits; b++) begin
			w = (w * 2) % STORE_ENTRIES;
		end
		return 32'(w);
	endfunction

	generate
		if ((STORE_ENTRIES & (STORE_ENTRIES - 1)) == 0) begin : g_pow2
			logic [IDX_W-1:0] slot_q;
			logic             done_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					slot_q <= word[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign slot = slot_q;
		end else begin : g_mod
			// four-bit chunks weighted by 2^(4i) mod depth and summed, the sum stays
			// below 256 times the depth, then eight compare and subtract steps, four
			// before mid_s2 and four before the slot register, bring it below the depth
			localparam int CHUNK = 4;
			localparam int STEPS = (WORD_W + CHUNK - 1) / CHUNK;
			localparam int PAD_W = STEPS * CHUNK;
			localparam int S_W   = IDX_W + 8;
			localparam logic [S_W-1:0] NMOD = S_W'(STORE_ENTRIES);

			function automatic logic [S_W-1:0] sub_steps(input logic [S_W-1:0] x,
				input int top);
				logic [S_W-1:0] r;
				r = x;
				for (int j = top; j > top - 4; j--) begin
					if (r >= (NMOD << j)) begin
						r = r - (NMOD << j);
					end
				end
				return r;
			endfunction

			logic [PAD_W-1:0] w_pad;
			logic [S_W-1:0]   term [STEPS];
			logic [S_W-1:0]   sum_d;
			logic [S_W-1:0]   sum_s1;
			logic [S_W-1:0]   mid_s2;
			logic [S_W-1:0]   fin;
			logic             vld_s1;
			logic             vld_s2;
			logic [IDX_W-1:0] slot_q;
			logic             done_q;

			assign w_pad = PAD_W'(word);

			for (genvar g = 0; g < STEPS; g++) begin : g_term
				localparam logic [S_W-1:0] WGT = S_W'(pow2_mod(g * CHUNK));
				assign term[g] = S_W'(w_pad[g*CHUNK +: CHUNK]) * WGT;
			end

			always_comb begin
				sum_d = '0;
				for (int i = 0; i < STEPS; i++) begin
					sum_d = sum_d + term[i];
				end
			end

			assign fin = sub_steps(mid_s2, 3);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					vld_s1 <= start;
					vld_s2 <= vld_s1;
					done_q <= vld_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sum_s1 <= sum_d;
				end
				if (vld_s1) begin
					mid_s2 <= sub_steps(sum_s1, 7);
				end
				if (vld_s2) begin
					slot_q <= fin[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign slot = slot_q;
		end
	endgenerate

endmodule

FILE: rtl/sv39ptw_store.sv
// page table entry store with clearing sweep after reset
`timescale 1ns / 1ps

module sv39ptw_store #(
	parameter int unsigned STORE_ENTRIES = sv39ptw_pkg::STORE_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sv39ptw_pkg::mem_cmd_t                 cmd,
	input  logic [$clog2(STORE_ENTRIES)-1:0]      addr,
	input  logic [sv39ptw_pkg::DATA_W-1:0]        wdata,
	output logic [sv39ptw_pkg::DATA_W-1:0]        rdata,
	output logic                                  busy
);
	import sv39ptw_pkg::*;

	localparam int IDX_W = $clog2(STORE_ENTRIES);

	logic [DATA_W-1:0] mem [STORE_ENTRIES];
	logic [DATA_W-1:0] rdata_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic              clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == IDX_W'(STORE_ENTRIES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= '0;
		end else if (cmd.we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clearing_q;

endmodule

FILE: rtl/sv39ptw_walk.sv
// walk sequencer: op decode, level iteration, a/d write-back, result register
`timescale 1ns / 1ps

module sv39ptw_walk #(
	parameter int unsigned STORE_ENTRIES = sv39ptw_pkg::STORE_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            op,
	input  logic [sv39ptw_pkg::ADDR_W-1:0]        entry_addr,
	input  logic [sv39ptw_pkg::DATA_W-1:0]        entry_data,
	input  logic [sv39ptw_pkg::VA_W-1:0]          virt_addr,
	input  logic [sv39ptw_pkg::ADDR_W-1:0]        root_addr,
	input  logic                                  store_access,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [sv39ptw_pkg::DATA_W-1:0]        read_data,
	output logic [sv39ptw_pkg::ADDR_W-1:0]        phys_addr,
	output logic                                  fault,
	output logic                                  slot_start,
	output logic [sv39ptw_pkg::WORD_W-1:0]        slot_word,
	input  logic                                  slot_done,
	input  logic [$clog2(STORE_ENTRIES)-1:0]      slot,
	output sv39ptw_pkg::mem_cmd_t                 mem_cmd,
	output logic [$clog2(STORE_ENTRIES)-1:0]      mem_addr,
	output logic [sv39ptw_pkg::DATA_W-1:0]        mem_wdata,
	input  logic [sv39ptw_pkg::DATA_W-1:0]        mem_rdata,
	input  logic                                  store_busy
);
	import sv39ptw_pkg::*;

	function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [VPN_W-1:0] v;
		case (lvl)
			2'd0:    v = va[38:30];
			2'd1:    v = va[29:21];
			default: v = va[20:12];
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] pte_word(input logic [ADDR_W-1:0] base,
		input logic [VPN_W-1:0] vpn);
		logic [ADDR_W-1:0] a;
		a = base + {{(ADDR_W - VPN_W - 3){1'b0}}, vpn, 3'b000};
		return a[ADDR_W-1:3];
	endfunction

	walk_state_t       state_q, state_d;
	op_t               op_q;
	op_t               op_in;
	logic [VA_W-1:0]   va_q;
	logic              store_q;
	logic [DATA_W-1:0] wdata_q;
	logic [1:0]        level_q;

	logic [DATA_W-1:0] res_rd_q;
	logic [ADDR_W-1:0] res_pa_q;
	logic              res_flt_q;
	logic [DATA_W-1:0] res_rd_d;
	logic [ADDR_W-1:0] res_pa_d;
	logic              res_flt_d;
	logic              load_res;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_rd_q;
	logic [ADDR_W-1:0] out_pa_q;
	logic              out_flt_q;
	logic              out_free;
	logic              out_load;

	logic              accept;
	logic              pte_v;
	logic              pte_leaf;
	logic              descend;
	logic              wb_needed;
	logic [DATA_W-1:0] upd;
	logic [ADDR_W-1:0] next_base;
	logic [ADDR_W-1:0] page_mask;
	logic [ADDR_W-1:0] leaf_pa;

	assign op_in    = op_t'(op);
	assign in_ready = (state_q == ST_IDLE) && !store_busy;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// pte evaluation on the registered read data
	assign pte_v     = mem_rdata[BIT_V];
	assign pte_leaf  = |mem_rdata[BIT_X:BIT_R];
	assign upd       = mem_rdata | (DATA_W'(1) << BIT_A) | (DATA_W'(store_q) << BIT_D);
	assign wb_needed = (upd != mem_rdata);
	assign next_base = {mem_rdata[PPN_LSB + PPN_W - 1:PPN_LSB], {PAGE_SHIFT{1'b0}}};
	assign descend   = (op_q == OP_XLATE) && pte_v && !pte_leaf && (level_q != 2'd2);

	always_comb begin
		case (level_q)
			2'd0:    page_mask = {{(ADDR_W - 30){1'b0}}, {30{1'b1}}};
			2'd1:    page_mask = {{(ADDR_W - 21){1'b0}}, {21{1'b1}}};
			default: page_mask = {{(ADDR_W - 12){1'b0}}, {12{1'b1}}};
		endcase
	end

	// superpage ppn bits below the page size come from the virtual address
	assign leaf_pa = ({upd[PPN_LSB + PPN_W - 1:PPN_LSB], {PAGE_SHIFT{1'b0}}} & ~page_mask)
		| (ADDR_W'(va_q) & page_mask);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (op_in == OP_NONE) ? ST_HOLD : ST_SLOT;
				end
			end
			ST_SLOT: begin
				if (slot_done) begin
					state_d = (op_q == OP_WRITE) ? ST_HOLD : ST_READ;
				end
			end
			ST_READ: begin
				state_d = descend ? ST_SLOT : ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		slot_start = 1'b0;
		slot_word  = entry_addr[ADDR_W-1:3];
		mem_cmd    = '0;
		mem_addr   = slot;
		mem_wdata  = wdata_q;
		load_res   = 1'b0;
		res_rd_d   = '0;
		res_pa_d   = '0;
		res_flt_d  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_in == OP_NONE) begin
						load_res = 1'b1;
					end else begin
						slot_start = 1'b1;
						if (op_in == OP_XLATE) begin
							slot_word = pte_word(root_addr, vpn_of(virt_addr, 2'd0));
						end
					end
				end
			end
			ST_SLOT: begin
				if (slot_done) begin
					if (op_q == OP_WRITE) begin
						mem_cmd.we = 1'b1;
						load_res   = 1'b1;
					end else begin
						mem_cmd.re = 1'b1;
					end
				end
			end
			ST_READ: begin
				if (descend) begin
					slot_start = 1'b1;
					slot_word  = pte_word(next_base, vpn_of(va_q, level_q + 2'd1));
				end else begin
					load_res = 1'b1;
					if (op_q == OP_READ) begin
						res_rd_d = mem_rdata;
					end else if (pte_v && pte_leaf) begin
						res_pa_d   = leaf_pa;
						mem_cmd.we = wb_needed;
						mem_wdata  = upd;
					end else begin
						res_flt_d = 1'b1;
					end
				end
			end
			ST_HOLD: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				level_q <= 2'd0;
			end else if ((state_q == ST_READ) && descend) begin
				level_q <= level_q + 2'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_in;
			va_q    <= virt_addr;
			store_q <= store_access;
			wdata_q <= entry_data;
		end
		if (load_res) begin
			res_rd_q  <= res_rd_d;
			res_pa_q  <= res_pa_d;
			res_flt_q <= res_flt_d;
		end
		if (out_load) begin
			out_rd_q  <= res_rd_q;
			out_pa_q  <= res_pa_q;
			out_flt_q <= res_flt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_rd_q;
	assign phys_addr = out_pa_q;
	assign fault     = out_flt_q;

endmodule

FILE: rtl/sv39_page_table_walker_core.sv
// sv39 page table walker top level: stream ports, store, slot unit, sequencer
`timescale 1ns / 1ps
// power-of-two STORE_ENTRIES: each store access follows one slot reduce, and a translate walks
//   one to three table levels, each a slot reduce plus one memory read in the single-port
//   entry store
// other depths: the slot reduce also registers the weighted sum and the partial remainder
// one item in flight; the next input transfer is taken once the result has moved from the
//   result register to the output register, while that result may still wait on the output
// after reset the store is swept to zero, s_axis_tready low meanwhile

module sv39_page_table_walker_core #(
	parameter int unsigned STORE_ENTRIES = sv39ptw_pkg::STORE_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// entry_addr[55:0], entry_data[119:56], virt_addr[158:120], root_addr[214:159], pad
	input  logic [sv39ptw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// op[1:0], store_access[2]
	input  logic [sv39ptw_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// read_data[63:0], phys_addr[119:64]
	output logic [sv39ptw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// fault
	output logic                                  m_axis_tuser
);
	import sv39ptw_pkg::*;

	localparam int IDX_W = $clog2(STORE_ENTRIES);

	// input field unpacking
	logic [1:0]        op;
	logic [ADDR_W-1:0] entry_addr;
	logic [DATA_W-1:0] entry_data;
	logic [VA_W-1:0]   virt_addr;
	logic [ADDR_W-1:0] root_addr;
	logic              store_access;

	assign op           = s_axis_tuser[1:0];
	assign store_access = s_axis_tuser[2];
	assign entry_addr   = s_axis_tdata[55:0];
	assign entry_data   = s_axis_tdata[119:56];
	assign virt_addr    = s_axis_tdata[158:120];
	assign root_addr    = s_axis_tdata[214:159];

	// results
	logic [DATA_W-1:0] read_data;
	logic [ADDR_W-1:0] phys_addr;
	logic              fault;

	// slot unit hookup
	logic              slot_start;
	logic [WORD_W-1:0] slot_word;
	logic              slot_done;
	logic [IDX_W-1:0]  slot;

	// store hookup
	mem_cmd_t          mem_cmd;
	logic [IDX_W-1:0]  mem_addr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;
	logic              store_busy;

	// word address to entry index, wraps at the store depth
	sv39ptw_slot #(
		.STORE_ENTRIES(STORE_ENTRIES)
	) u_slot (
		.clk   (clk),
		.arst_n(arst_n),
		.start (slot_start),
		.word  (slot_word),
		.done  (slot_done),
		.slot  (slot)
	);

	// entry store, one access per cycle outside the clearing sweep, registered read data
	sv39ptw_store #(
		.STORE_ENTRIES(STORE_ENTRIES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata),
		.busy  (store_busy)
	);

	// walk sequencer with the output register
	sv39ptw_walk #(
		.STORE_ENTRIES(STORE_ENTRIES)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.op          (op),
		.entry_addr  (entry_addr),
		.entry_data  (entry_data),
		.virt_addr   (virt_addr),
		.root_addr   (root_addr),
		.store_access(store_access),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.read_data   (read_data),
		.phys_addr   (phys_addr),
		.fault       (fault),
		.slot_start  (slot_start),
		.slot_word   (slot_word),
		.slot_done   (slot_done),
		.slot        (slot),
		.mem_cmd     (mem_cmd),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata),
		.store_busy  (store_busy)
	);

	// output packing
	assign m_axis_tdata = {phys_addr, read_data};
	assign m_axis_tuser = fault;

endmodule
